FILE: hdl/block_buffer_cache_lru_unit_macros.svh
// Assertion macros for the buffer cache tag store.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef BLOCK_BUFFER_CACHE_LRU_UNIT_MACROS_SVH
`define BLOCK_BUFFER_CACHE_LRU_UNIT_MACROS_SVH

// property checked at every rising clock edge out of reset
`define BBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define BBC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/bbc_pkg.sv
// Shared types, codes and helpers for the buffer cache tag store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    localparam int DEF_NUM_SLOTS = 32;
    localparam int SLOT_W        = 5;
    localparam int DEV_W         = 8;
    localparam int BLK_W         = 32;
    localparam int REF_W         = 8;
    localparam int TICK_W        = 32;
    localparam logic [REF_W-1:0] REF_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_BAD_SLOT = 2'd2
    } t_status;

    typedef struct packed {
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block;
        logic [REF_W-1:0]  refcount;
        logic [TICK_W-1:0] stamp;
        logic              data_valid;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic clear;
        logic sample;
    } t_scan_ctl;

    typedef struct packed {
        logic              hit;
        logic [REF_W-1:0]  hit_ref;
        logic              hit_valid;
        logic [TICK_W-1:0] hit_stamp;
        logic              vic_found;
        logic [TICK_W-1:0] vic_stamp;
    } t_scan_res;

    function automatic logic [REF_W-1:0] sat_inc(input logic [REF_W-1:0] v);
        sat_inc = (v == REF_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bbc_scan.sv
// Tag match and LRU victim tracker fed by the slot scan.
// Depends on bbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbc_scan #(
    parameter int NUM_SLOTS = bbc_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bbc_pkg::t_scan_ctl             i_ctl,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]   i_idx,
    input  wire bbc_pkg::t_entry                i_entry,
    input  wire logic [bbc_pkg::DEV_W-1:0]      i_device,
    input  wire logic [bbc_pkg::BLK_W-1:0]      i_block,
    output bbc_pkg::t_scan_res                  o_res,
    output logic      [$clog2(NUM_SLOTS)-1:0]   o_hit_idx,
    output logic      [$clog2(NUM_SLOTS)-1:0]   o_vic_idx
);
    import bbc_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);

    logic              r_hit, r_vic_found;
    logic [REF_W-1:0]  r_hit_ref;
    logic              r_hit_valid;
    logic [TICK_W-1:0] r_hit_stamp, r_vic_stamp;
    logic [IW-1:0]     r_hit_idx, r_vic_idx;
    logic              w_match, w_cand;

    assign w_match = (i_entry.device == i_device) && (i_entry.block == i_block);
    assign w_cand  = (i_entry.refcount == '0) &&
                     (!r_vic_found || (i_entry.stamp < r_vic_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_hit       <= 1'b0;
            r_vic_found <= 1'b0;
        end else if (i_ctl.sample) begin
            if (!r_hit && w_match) begin
                r_hit <= 1'b1;
            end
            if (w_cand) begin
                r_vic_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sample && !r_hit && w_match) begin
            r_hit_idx   <= i_idx;
            r_hit_ref   <= i_entry.refcount;
            r_hit_valid <= i_entry.data_valid;
            r_hit_stamp <= i_entry.stamp;
        end
        if (i_ctl.sample && w_cand) begin
            r_vic_idx   <= i_idx;
            r_vic_stamp <= i_entry.stamp;
        end
    end

    always_comb begin
        o_res.hit       = r_hit;
        o_res.hit_ref   = r_hit_ref;
        o_res.hit_valid = r_hit_valid;
        o_res.hit_stamp = r_hit_stamp;
        o_res.vic_found = r_vic_found;
        o_res.vic_stamp = r_vic_stamp;
    end

    assign o_hit_idx = r_hit_idx;
    assign o_vic_idx = r_vic_idx;

endmodule

`default_nettype wire

FILE: hdl/block_buffer_cache_lru_unit.sv
// Buffer cache tag store: sequencer, entry RAM and scan unit.
// A read issues one RAM read per used slot, drains the last read, then writes back and
// loads the result; release, pin and unpin read the named slot first, or go straight to
// the result when the slot is rejected. The result waits to load while the previous reply
// is still held. One transaction at a time, accepted the cycle after the result loads.
// Synchronous reset clears the fill count and control state; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "block_buffer_cache_lru_unit_macros.svh"

module block_buffer_cache_lru_unit #(
    parameter int NUM_SLOTS = bbc_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [bbc_pkg::DEV_W-1:0]     i_device,
    input  wire logic [bbc_pkg::BLK_W-1:0]     i_block_number,
    input  wire logic [bbc_pkg::SLOT_W-1:0]    i_slot_in,
    input  wire logic [bbc_pkg::TICK_W-1:0]    i_now_tick,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [bbc_pkg::SLOT_W-1:0]    o_slot_out,
    output logic                               o_hit,
    output logic                               o_need_disk_read,
    output logic      [1:0]                    o_status
);
    import bbc_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam logic [CW-1:0] FULL = CW'(NUM_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_RD   = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_used, n_used;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_rv, n_rv;
    logic [IW-1:0]     r_ridx;
    t_opcode           r_op;
    logic [DEV_W-1:0]  r_dev;
    logic [BLK_W-1:0]  r_blk;
    logic [SLOT_W-1:0] r_slot;
    logic [TICK_W-1:0] r_now;
    logic              r_bad;

    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_slot_out, n_slot_out;
    logic              r_hit_o, n_hit_o;
    logic              r_need, n_need;
    t_status           r_status, n_status;

    logic              w_accept, w_issue, w_load, w_slot_ok;
    logic              w_we, w_re;
    logic [IW-1:0]     w_waddr, w_raddr;
    t_entry            w_wentry, w_rentry;
    logic [ENTRY_W-1:0] w_rdata;
    t_scan_ctl         w_ctl;
    t_scan_res         w_res;
    logic [IW-1:0]     w_hit_idx, w_vic_idx;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_issue    = (r_state == S_SCAN) && (r_idx < r_used);
    assign w_load     = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign w_slot_ok  = SW'(i_slot_in) < SW'(r_used);
    assign w_rentry   = t_entry'(w_rdata);

    assign w_re    = w_issue || (r_state == S_RD);
    assign w_raddr = (r_state == S_RD) ? r_slot[IW-1:0] : r_idx[IW-1:0];

    assign w_ctl.clear  = w_accept;
    assign w_ctl.sample = r_rv;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_rv        = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_slot_out  = r_slot_out;
        n_hit_o     = r_hit_o;
        n_need      = r_need;
        n_status    = r_status;
        w_we        = 1'b0;
        w_waddr     = r_slot[IW-1:0];
        w_wentry    = w_rentry;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    if (t_opcode'(i_opcode) == OP_READ) begin
                        n_state = S_SCAN;
                    end else if (w_slot_ok) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                n_rv = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_hit_o  = 1'b0;
                n_need   = 1'b0;
                n_status = ST_OK;
                n_slot_out = r_slot;
                w_wentry.device     = r_dev;
                w_wentry.block      = r_blk;
                w_wentry.refcount   = 8'd1;
                w_wentry.data_valid = 1'b1;
                if (r_op == OP_READ) begin
                    n_need = 1'b1;
                    priority if (w_res.hit) begin
                        w_we                = w_load;
                        w_waddr             = w_hit_idx;
                        w_wentry.refcount   = sat_inc(w_res.hit_ref);
                        w_wentry.stamp      = w_res.hit_stamp;
                        n_slot_out          = SLOT_W'(w_hit_idx);
                        n_hit_o             = 1'b1;
                        n_need              = !w_res.hit_valid;
                    end else if (r_used < FULL) begin
                        w_we           = w_load;
                        w_waddr        = r_used[IW-1:0];
                        w_wentry.stamp = '0;
                        n_slot_out     = SLOT_W'(r_used);
                        if (w_load) begin
                            n_used = r_used + 1'b1;
                        end
                    end else if (w_res.vic_found) begin
                        w_we           = w_load;
                        w_waddr        = w_vic_idx;
                        w_wentry.stamp = w_res.vic_stamp;
                        n_slot_out     = SLOT_W'(w_vic_idx);
                    end else begin
                        n_slot_out = '0;
                        n_need     = 1'b0;
                        n_status   = ST_NO_FREE;
                    end
                end else begin
                    w_wentry = w_rentry;
                    priority if (r_bad) begin
                        n_status = ST_BAD_SLOT;
                    end else if (r_op == OP_PIN) begin
                        w_we              = w_load;
                        w_wentry.refcount = sat_inc(w_rentry.refcount);
                    end else if (w_rentry.refcount == '0) begin
                        n_status = ST_BAD_SLOT;
                    end else begin
                        w_we              = w_load;
                        w_wentry.refcount = w_rentry.refcount - 1'b1;
                        if (r_op == OP_RELEASE && w_rentry.refcount == 8'd1) begin
                            w_wentry.stamp = r_now;
                        end
                    end
                end
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_slot_out = r_slot_out;
                    n_hit_o    = r_hit_o;
                    n_need     = r_need;
                    n_status   = r_status;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_idx       <= n_idx;
            r_rv        <= n_rv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx     <= r_idx[IW-1:0];
        r_slot_out <= n_slot_out;
        r_hit_o    <= n_hit_o;
        r_need     <= n_need;
        r_status   <= n_status;
        if (w_accept) begin
            r_op   <= t_opcode'(i_opcode);
            r_dev  <= i_device;
            r_blk  <= i_block_number;
            r_slot <= i_slot_in;
            r_now  <= i_now_tick;
            r_bad  <= !w_slot_ok;
        end
    end

    bbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bbc_scan #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_idx     (r_ridx),
        .i_entry   (w_rentry),
        .i_device  (r_dev),
        .i_block   (r_blk),
        .o_res     (w_res),
        .o_hit_idx (w_hit_idx),
        .o_vic_idx (w_vic_idx)
    );

    assign o_out_valid      = r_out_valid;
    assign o_slot_out       = r_slot_out;
    assign o_hit            = r_hit_o;
    assign o_need_disk_read = r_need;
    assign o_status         = r_status;

    `BBC_ASSERT(a_used_bound, r_used <= FULL, "fill count past slot count")
    `BBC_ASSERT_IMP(a_sample_in_scan, r_rv, r_state == S_SCAN, "scan sample outside scan")
    `BBC_ASSERT_IMP(a_used_grow, $past(i_rst_n) && (r_used != $past(r_used)),
        $past(w_we) && ($past(r_op) == OP_READ) && (r_used == $past(r_used) + 1'b1),
        "fill count changed without a fresh allocation")
    `BBC_ASSERT_IMP(a_no_free_full, o_out_valid && (o_status == ST_NO_FREE),
        (r_used == FULL) && !o_hit, "no-free status while slots remain")

endmodule

`default_nettype wire

FILE: tb/sv/tb_block_buffer_cache_lru_unit.sv
// Testbench for block_buffer_cache_lru_unit: directed and random lookups, releases, pins, unpins.
// A scoreboard class predicts every reply and checks it field by field; tasks drive the ports.
// Depends on bbc_pkg and the block_buffer_cache_lru_unit RTL.
`timescale 1ns / 1ps

module tb_block_buffer_cache_lru_unit;
    import bbc_pkg::*;

    localparam int NSLOTS       = DEF_NUM_SLOTS;
    localparam int N_ITEMS      = 1050;
    localparam int POOL_SIZE    = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 40;

    typedef enum int {
        MODE_STEADY    = 0,
        MODE_SRC_IDLE  = 1,
        MODE_SINK_IDLE = 2,
        MODE_BOTH_IDLE = 3
    } t_idle_mode;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              need_read;
        t_status           status;
    } t_lookup_result;

    class tag_store_scoreboard;
        int                fill_count;
        logic [DEV_W-1:0]  tag_dev   [NSLOTS];
        logic [BLK_W-1:0]  tag_blk   [NSLOTS];
        logic [REF_W-1:0]  ref_cnt   [NSLOTS];
        logic [TICK_W-1:0] rel_stamp [NSLOTS];
        bit                data_ok   [NSLOTS];
        t_lookup_result    pending_replies[$];
        int unsigned       errors, replies_seen, hits, fills, evictions;
        int unsigned       no_free, bad_slot, saturated;

        function new();
            fill_count = 0;
            for (int i = 0; i < NSLOTS; i++) begin
                tag_dev[i]   = '0;
                tag_blk[i]   = '0;
                ref_cnt[i]   = '0;
                rel_stamp[i] = '0;
                data_ok[i]   = 1'b0;
            end
            errors = 0; replies_seen = 0; hits = 0; fills = 0; evictions = 0;
            no_free = 0; bad_slot = 0; saturated = 0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // predicts the reply of an accepted transaction and updates the tag store copy
        function t_lookup_result note_request(t_opcode op, logic [DEV_W-1:0] dev,
                                              logic [BLK_W-1:0] blk, logic [SLOT_W-1:0] slot,
                                              logic [TICK_W-1:0] tick);
            t_lookup_result res;
            int             victim;
            res.slot      = slot;
            res.hit       = 1'b0;
            res.need_read = 1'b0;
            res.status    = ST_OK;
            victim        = -1;
            if (op == OP_READ) begin
                res.slot = '0;
                for (int i = 0; i < fill_count; i++) begin
                    if (victim < 0 && tag_dev[i] == dev && tag_blk[i] == blk) victim = i;
                end
                if (victim >= 0) begin
                    hits++;
                    if (ref_cnt[victim] == REF_MAX) saturated++;
                    else ref_cnt[victim]++;
                    res.hit       = 1'b1;
                    res.need_read = !data_ok[victim];
                end else begin
                    if (fill_count < NSLOTS) begin
                        victim = fill_count;
                        fill_count++;
                        fills++;
                    end else begin
                        // oldest unreferenced stamp, lowest slot on a tie
                        for (int i = 0; i < NSLOTS; i++) begin
                            if (ref_cnt[i] == 0 && (victim < 0 || rel_stamp[i] < rel_stamp[victim]))
                                victim = i;
                        end
                        if (victim >= 0) evictions++;
                    end
                    if (victim < 0) begin
                        res.status = ST_NO_FREE;
                        no_free++;
                    end else begin
                        tag_dev[victim] = dev;
                        tag_blk[victim] = blk;
                        ref_cnt[victim] = 1;
                        res.need_read   = 1'b1;
                    end
                end
                if (victim >= 0) begin
                    data_ok[victim] = 1'b1;
                    res.slot        = SLOT_W'(victim);
                end
            end else if (slot >= fill_count) begin
                res.status = ST_BAD_SLOT;
                bad_slot++;
            end else if (op == OP_PIN) begin
                if (ref_cnt[slot] == REF_MAX) saturated++;
                else ref_cnt[slot]++;
            end else if (ref_cnt[slot] == 0) begin
                res.status = ST_BAD_SLOT;
                bad_slot++;
            end else begin
                ref_cnt[slot]--;
                if (op == OP_RELEASE && ref_cnt[slot] == 0) rel_stamp[slot] = tick;
            end
            pending_replies.push_back(res);
            return res;
        endfunction

        function void mismatch(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_reply(t_lookup_result got);
            t_lookup_result want;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply, expected none, actual slot=%0d hit=%0d need=%0d st=%0d",
                         $time, got.slot, got.hit, got.need_read, got.status);
                return;
            end
            want = pending_replies.pop_front();
            replies_seen++;
            if (got.slot !== want.slot) mismatch("slot_out", want.slot, got.slot);
            if (got.hit !== want.hit) mismatch("hit", want.hit, got.hit);
            if (got.need_read !== want.need_read)
                mismatch("need_disk_read", want.need_read, got.need_read);
            if (got.status !== want.status) mismatch("status", want.status, got.status);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_opcode;
    logic [DEV_W-1:0]    i_device;
    logic [BLK_W-1:0]    i_block_number;
    logic [SLOT_W-1:0]   i_slot_in;
    logic [TICK_W-1:0]   i_now_tick;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [SLOT_W-1:0]   o_slot_out;
    logic                o_hit;
    logic                o_need_disk_read;
    logic [1:0]          o_status;

    tag_store_scoreboard sb;
    t_idle_mode          idle_mode;
    bit                  hold_replies;
    int                  n_sent;
    logic [TICK_W-1:0]   tick_now;
    logic [DEV_W-1:0]    pool_dev [POOL_SIZE];
    logic [BLK_W-1:0]    pool_blk [POOL_SIZE];
    logic [SLOT_W-1:0]   held[$];

    block_buffer_cache_lru_unit #(
        .NUM_SLOTS(NSLOTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_device         (i_device),
        .i_block_number   (i_block_number),
        .i_slot_in        (i_slot_in),
        .i_now_tick       (i_now_tick),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_slot_out       (o_slot_out),
        .o_hit            (o_hit),
        .o_need_disk_read (o_need_disk_read),
        .o_status         (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_txn(input t_opcode op, input logic [DEV_W-1:0] dev,
                            input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] slot,
                            input logic [TICK_W-1:0] tick, output t_lookup_result pred);
        int gap_pct;
        gap_pct = (idle_mode == MODE_SRC_IDLE) ? 66 : (idle_mode == MODE_BOTH_IDLE) ? 20 : 0;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_opcode       = op;
        i_device       = dev;
        i_block_number = blk;
        i_slot_in      = slot;
        i_now_tick     = tick;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = sb.note_request(op, dev, blk, slot, tick);
        n_sent++;
    endtask

    // drop valid after the last accepted transaction, then drain
    task automatic wait_for_replies();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic bump_tick();
        if ($urandom_range(0, 99) < 3) tick_now = $urandom;
        else tick_now = tick_now + $urandom_range(0, 3);
    endtask

    // read a tag and keep the granted reference
    task automatic read_and_hold(input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk);
        t_lookup_result r;
        send_txn(OP_READ, dev, blk, SLOT_W'($urandom), tick_now, r);
        if (r.status == ST_OK) held.push_back(r.slot);
    endtask

    // try to grab more references than there are slots, then give them all back
    task automatic hog_all_slots();
        t_lookup_result    r;
        logic [SLOT_W-1:0] s;
        repeat (NSLOTS + 4) read_and_hold(DEV_W'($urandom), $urandom);
        while (held.size() > 0) begin
            bump_tick();
            s = held.pop_front();
            send_txn(OP_RELEASE, DEV_W'($urandom), $urandom, s, tick_now, r);
        end
    endtask

    task automatic random_step();
        t_lookup_result    r;
        int                pick, idx;
        logic [SLOT_W-1:0] s;
        pick = $urandom_range(0, 99);
        bump_tick();
        if (held.size() > 12) pick = 50;
        idx = (held.size() > 0) ? $urandom_range(0, held.size() - 1) : 0;
        s   = (held.size() > 0) ? held[idx] : '0;
        if (pick < 45) begin
            idx = $urandom_range(0, POOL_SIZE - 1);
            read_and_hold(pool_dev[idx], pool_blk[idx]);
        end else if (pick < 50) begin
            read_and_hold(DEV_W'($urandom), $urandom);
        end else if (pick < 75 && held.size() > 0) begin
            send_txn(OP_RELEASE, DEV_W'($urandom), $urandom, s, tick_now, r);
            held.delete(idx);
        end else if (pick < 83 && held.size() > 0) begin
            send_txn(OP_PIN, DEV_W'($urandom), $urandom, s, tick_now, r);
            held.push_back(s);
        end else if (pick < 90 && held.size() > 0) begin
            send_txn(OP_UNPIN, DEV_W'($urandom), $urandom, s, tick_now, r);
            held.delete(idx);
        end else begin
            send_txn(t_opcode'($urandom_range(0, 3)), DEV_W'($urandom), $urandom,
                     SLOT_W'($urandom), $urandom, r);
        end
    endtask

    initial begin : reply_sink
        int stall_pct;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_replies) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_replies = 1'b0;
            end else begin
                stall_pct = (idle_mode == MODE_SINK_IDLE) ? 66 :
                            (idle_mode == MODE_BOTH_IDLE) ? 20 : 0;
                i_out_ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : reply_monitor
        t_lookup_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.slot      = o_slot_out;
            got.hit       = o_hit;
            got.need_read = o_need_disk_read;
            got.status    = t_status'(o_status);
            sb.check_reply(got);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_block_buffer_cache_lru_unit: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_lookup_result r;
        t_idle_mode     mode_next;
        int             iter;
        sb             = new();
        idle_mode      = MODE_STEADY;
        hold_replies   = 1'b0;
        n_sent         = 0;
        tick_now       = '0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_READ;
        i_device       = '0;
        i_block_number = '0;
        i_slot_in      = '0;
        i_now_tick     = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_dev[i] = DEV_W'($urandom);
            pool_blk[i] = $urandom;
        end
        // tags that differ in only one of device and block
        pool_dev[1] = pool_dev[0];
        pool_blk[2] = pool_blk[0];
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_txn(OP_READ,    8'h00, 32'h0000_0000, 5'd0,  32'h0, r);
        send_txn(OP_READ,    8'h00, 32'h0000_0000, 5'd31, 32'h0, r);
        send_txn(OP_READ,    8'hFF, 32'hFFFF_FFFF, 5'd0,  32'h0, r);
        send_txn(OP_READ,    8'h00, 32'hFFFF_FFFF, 5'd0,  32'h0, r);
        send_txn(OP_READ,    8'hFF, 32'h0000_0000, 5'd0,  32'h0, r);
        send_txn(OP_RELEASE, 8'h00, 32'h0,         5'd1,  32'hFFFF_FFFF, r);
        send_txn(OP_RELEASE, 8'h00, 32'h0,         5'd1,  32'h0000_0001, r);
        send_txn(OP_UNPIN,   8'h00, 32'h0,         5'd1,  32'h0, r);
        send_txn(OP_RELEASE, 8'h00, 32'h0,         5'd31, 32'h0, r);
        send_txn(OP_PIN,     8'h00, 32'h0,         5'd31, 32'h0, r);
        send_txn(OP_UNPIN,   8'h00, 32'h0,         5'd4,  32'h0, r);
        send_txn(OP_PIN,     8'h00, 32'h0,         5'd0,  32'h0, r);
        send_txn(OP_UNPIN,   8'h00, 32'h0,         5'd0,  32'h0, r);
        send_txn(OP_RELEASE, 8'h00, 32'h0,         5'd0,  32'h0, r);
        send_txn(OP_RELEASE, 8'h00, 32'h0,         5'd0,  32'h0, r);
        send_txn(OP_READ,    8'h00, 32'h0000_0000, 5'd0,  32'h0, r);
        send_txn(OP_UNPIN,   8'h00, 32'h0,         5'd2,  32'h7, r);
        send_txn(OP_RELEASE, 8'h00, 32'h0,         5'd3,  32'h5, r);
        send_txn(OP_READ,    8'hFF, 32'hFFFF_FFFF, 5'd0,  32'h0, r);
        wait_for_replies();

        // saturate one count, then unpin it past zero
        idle_mode = MODE_BOTH_IDLE;
        repeat (257) send_txn(OP_PIN, DEV_W'($urandom), $urandom, 5'd0, $urandom, r);
        repeat (257) send_txn(OP_UNPIN, DEV_W'($urandom), $urandom, 5'd0, $urandom, r);

        iter = 0;
        while (n_sent < N_ITEMS) begin
            mode_next = t_idle_mode'((iter / 90) % 4);
            if (mode_next != idle_mode) begin
                wait_for_replies();
                idle_mode = mode_next;
            end
            if (iter == 150) hold_replies = 1'b1;
            if (iter == 300) wait_for_replies();
            if (iter == 60 || iter == 260) hog_all_slots();
            else random_step();
            iter++;
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_for_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d transactions: %0d hits, %0d fills, %0d evictions, %0d no-free, %0d bad-slot",
                 n_sent, sb.hits, sb.fills, sb.evictions, sb.no_free, sb.bad_slot);
        $display("%0d saturated counts, %0d replies checked, %0d mismatches",
                 sb.saturated, sb.replies_seen, sb.errors);
        if (sb.errors == 0) $display("tb_block_buffer_cache_lru_unit: PASS");
        else $display("tb_block_buffer_cache_lru_unit: FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/bbc_pkg.sv
hdl/bbc_ram.sv
hdl/bbc_scan.sv
hdl/block_buffer_cache_lru_unit.sv
tb/sv/tb_block_buffer_cache_lru_unit.sv
